>>> rtl/core/bgia_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgia_pkg
// Shared types and constants for the brightness gated image average block.
// -----------------------------------------------------------------------------
package bgia_pkg;

    localparam int MAX_IMAGES_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SPAN = 2'd1;

    localparam logic [4:0] IMAGE_COUNT_RST = 5'd1;
    localparam logic [7:0] CUTOFF_SPAN_RST = 8'd200;

    typedef struct packed {
        logic [7:0] pattern_level;
        logic [3:0] image_index;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       last_image;
    } t_in_item;

    typedef struct packed {
        logic [7:0] avg_red;
        logic [7:0] avg_green;
        logic [7:0] avg_blue;
        logic [4:0] included_count;
    } t_out_item;

endpackage

>>> rtl/core/brightness_gated_image_average.sv
`timescale 1ns / 1ps
// Throughput: one input beat per cycle within a pixel while o_full is low;
// the divider takes one pixel at a time (load, 8 quotient bits, hand-off)
// and takes a new one only after the last is handed off; a two-entry
// queue of pixel totals lets the accumulator run ahead of it.
// Reset: synchronous, active low; clears sums, empties queue and output,
// idles the divider, and returns image_count to 1 and cutoff_span to 200.
// -----------------------------------------------------------------------------
// brightness_gated_image_average
// Brightness gated per-pixel average of several source images.
// -----------------------------------------------------------------------------
module brightness_gated_image_average
    import bgia_pkg::*;
#(
    parameter int MAX_IMAGES = MAX_IMAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in_item              i_in_item,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_IMAGES + 1);
    localparam int SW = 8 + CW;
    localparam int EW = 3 * SW + CW;

    logic [4:0]    r_image_count;
    logic [7:0]    r_cutoff_span;
    logic          accept;
    logic          push_tot;
    logic [EW-1:0] totals;
    logic [EW-1:0] q_data;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full;
    assign accept      = i_push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_count <= IMAGE_COUNT_RST;
            r_cutoff_span <= CUTOFF_SPAN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_COUNT: r_image_count <= i_cfg_data[4:0];
                REG_CUTOFF_SPAN: r_cutoff_span <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    bgia_front #(
        .MAX_IMAGES (MAX_IMAGES),
        .CW         (CW),
        .SW         (SW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_image_count (r_image_count),
        .i_cutoff_span (r_cutoff_span),
        .o_push        (push_tot),
        .o_totals      (totals)
    );

    bgia_queue #(
        .EW (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_tot),
        .i_data  (totals),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bgia_div #(
        .MAX_IMAGES (MAX_IMAGES),
        .CW         (CW),
        .SW         (SW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_totals  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_item    (o_out_item)
    );

endmodule

>>> rtl/core/bgia_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgia_front
// Threshold test and per-channel accumulation; emits pixel totals on last.
// -----------------------------------------------------------------------------
module bgia_front
    import bgia_pkg::*;
#(
    parameter int MAX_IMAGES = MAX_IMAGES_DEF,
    parameter int CW         = $clog2(MAX_IMAGES + 1),
    parameter int SW         = 8 + CW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_in_item           i_item,
    input  logic [4:0]         i_image_count,
    input  logic [7:0]         i_cutoff_span,
    output logic               o_push,
    output logic [3*SW+CW-1:0] o_totals
);

    logic [SW-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] n_sum_r, n_sum_g, n_sum_b;
    logic [CW-1:0] n_cnt;
    logic [12:0]   lhs;
    logic [12:0]   rhs;
    logic          take;

    always_comb begin
        lhs  = 13'(i_item.pattern_level) * 13'(i_image_count);
        rhs  = 13'(i_cutoff_span) * 13'(i_item.image_index);
        take = (lhs >= rhs) && (r_cnt < CW'(MAX_IMAGES));
        n_sum_r = r_sum_r;
        n_sum_g = r_sum_g;
        n_sum_b = r_sum_b;
        n_cnt   = r_cnt;
        if (take) begin
            n_sum_r = r_sum_r + SW'(i_item.pixel_red);
            n_sum_g = r_sum_g + SW'(i_item.pixel_green);
            n_sum_b = r_sum_b + SW'(i_item.pixel_blue);
            n_cnt   = r_cnt + CW'(1);
        end
    end

    assign o_push   = i_accept && i_item.last_image;
    assign o_totals = {n_sum_r, n_sum_g, n_sum_b, n_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            if (i_item.last_image) begin
                r_sum_r <= '0;
                r_sum_g <= '0;
                r_sum_b <= '0;
                r_cnt   <= '0;
            end else begin
                r_sum_r <= n_sum_r;
                r_sum_g <= n_sum_g;
                r_sum_b <= n_sum_b;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

>>> rtl/core/bgia_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgia_queue
// Two-entry queue of pixel totals between accumulator and divider.
// -----------------------------------------------------------------------------
module bgia_queue
    import bgia_pkg::*;
#(
    parameter int EW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_data,
    input  logic          i_pop,
    output logic [EW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    logic [EW-1:0] r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

>>> rtl/core/bgia_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bgia_div
// Restoring divider, one quotient bit per cycle on all three channels,
// with the result register that feeds the output port.
// -----------------------------------------------------------------------------
module bgia_div
    import bgia_pkg::*;
#(
    parameter int MAX_IMAGES = MAX_IMAGES_DEF,
    parameter int CW         = $clog2(MAX_IMAGES + 1),
    parameter int SW         = 8 + CW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [3*SW+CW-1:0] i_totals,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output t_out_item          o_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    r_state;
    logic [2:0]    r_step;
    logic [SW-1:0] r_rem_r, r_rem_g, r_rem_b;
    logic [SW-1:0] r_dsh;
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_q_r, r_q_g, r_q_b;
    logic          r_out_valid;
    t_out_item     r_out;
    logic          ge_r, ge_g, ge_b;
    logic          load_out;

    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign load_out = (r_state == ST_HOLD) && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_item   = r_out;

    assign ge_r = r_rem_r >= r_dsh;
    assign ge_g = r_rem_g >= r_dsh;
    assign ge_b = r_rem_b >= r_dsh;

    // datapath: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem_r <= i_totals[3*SW+CW-1 -: SW];
            r_rem_g <= i_totals[2*SW+CW-1 -: SW];
            r_rem_b <= i_totals[SW+CW-1 -: SW];
            r_cnt   <= i_totals[CW-1:0];
            r_dsh   <= SW'(i_totals[CW-1:0]) << 7;
            r_q_r   <= '0;
            r_q_g   <= '0;
            r_q_b   <= '0;
        end else if (r_state == ST_DIV) begin
            if (ge_r) r_rem_r <= r_rem_r - r_dsh;
            if (ge_g) r_rem_g <= r_rem_g - r_dsh;
            if (ge_b) r_rem_b <= r_rem_b - r_dsh;
            r_q_r <= {r_q_r[6:0], ge_r};
            r_q_g <= {r_q_g[6:0], ge_g};
            r_q_b <= {r_q_b[6:0], ge_b};
            r_dsh <= r_dsh >> 1;
        end
        if (load_out) begin
            // empty pixel: divisor of zero would give all ones
            r_out.avg_red        <= (r_cnt == '0) ? 8'd0 : r_q_r;
            r_out.avg_green      <= (r_cnt == '0) ? 8'd0 : r_q_g;
            r_out.avg_blue       <= (r_cnt == '0) ? 8'd0 : r_q_b;
            r_out.included_count <= 5'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= ST_DIV;
                        r_step  <= 3'd7;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for brightness_gated_image_average. A directed script
// covers the gate thresholds, empty and capped pixels and the register
// extremes, then random pixel streams run under several register settings.
// Every result beat is compared with an in-bench model of the averaging,
// or with the value given in a typed script row.
module tb;
    import bgia_pkg::*;

    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 500;
    localparam int PHASES       = 9;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 20;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {PIX_CLEAN, PIX_NOISE, PIX_OVERLONG} t_pixel_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in_item              beat;
        logic [4:0]            reps;
        logic                  typed;
        t_out_item             want;
    } t_stim_row;

    localparam int N_ROWS = 24;
    // Rows start under reset settings: image_count 1, cutoff_span 200.
    localparam t_stim_row SCRIPT [N_ROWS] = '{
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 5'd1}},
        // nothing passes the gate
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hFF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b1, '0},
        // exactly on the threshold, then one below it
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hC8, 4'h1, 8'h64, 8'h32, 8'h00, 1'b1},
          5'd1, 1'b1, '{8'h64, 8'h32, 8'h00, 5'd1}},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hC7, 4'h1, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b1, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'h0, 8'hAA, 8'h55, 8'hAA, 1'b0},
          5'd1, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hFF, 4'h1, 8'h55, 8'hAA, 8'h55, 1'b0},
          5'd1, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h07, 4'h2, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b0, '0},
        // twenty beats in one pixel: count saturates at sixteen
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'h0, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd20, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 5'd16}},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h80, 4'h0, 8'h01, 8'h02, 8'h03, 1'b0},
          5'd3, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h80, 4'h0, 8'hF0, 8'h0F, 8'h80, 1'b1},
          5'd1, 1'b0, '0},
        // zero image count: only index 0 gets through
        '{ROW_CFG, REG_IMAGE_COUNT, 8'h00, '0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hFF, 4'h1, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b1, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'h0, 8'h12, 8'h34, 8'h56, 1'b1},
          5'd1, 1'b1, '{8'h12, 8'h34, 8'h56, 5'd1}},
        // zero span: any index passes
        '{ROW_CFG, REG_CUTOFF_SPAN, 8'h00, '0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'hF, 8'h80, 8'h80, 8'h80, 1'b1},
          5'd1, 1'b1, '{8'h80, 8'h80, 8'h80, 5'd1}},
        '{ROW_CFG, REG_IMAGE_COUNT, 8'h1F, '0, 5'd0, 1'b0, '0},
        '{ROW_CFG, REG_CUTOFF_SPAN, 8'hFF, '0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'hFF, 4'hF, 8'h3C, 8'h3C, 8'h3C, 1'b0},
          5'd1, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h80, 4'hF, 8'h11, 8'h22, 8'h33, 1'b0},
          5'd1, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h64, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
          5'd1, 1'b0, '0},
        '{ROW_CFG, REG_IMAGE_COUNT, 8'h10, '0, 5'd0, 1'b0, '0},
        '{ROW_CFG, REG_CUTOFF_SPAN, 8'h10, '0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h01, 4'h1, 8'hFE, 8'hFD, 8'hFC, 1'b0},
          5'd1, 1'b0, '0},
        '{ROW_ITEM, REG_IMAGE_COUNT, 8'h00, '{8'h00, 4'h1, 8'h01, 8'h01, 8'h01, 1'b1},
          5'd1, 1'b0, '0}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_push      = 1'b0;
    logic                  i_pop       = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    t_in_item              i_in_item   = '0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_full;
    logic                  o_empty;
    logic                  o_cfg_ready;
    t_out_item             o_out_item;

    // shadow of the block's registers and pixel accumulators
    logic [4:0]  shadow_count = IMAGE_COUNT_RST;
    logic [7:0]  shadow_span  = CUTOFF_SPAN_RST;
    logic [11:0] acc_red      = '0;
    logic [11:0] acc_green    = '0;
    logic [11:0] acc_blue     = '0;
    logic [4:0]  acc_taken    = '0;
    t_out_item   pending_pixels [$];

    int err_cnt     = 0;
    int beats_in    = 0;
    int pixels_out  = 0;
    int cfg_writes  = 0;
    int cycles      = 0;
    int burst_left  = 1;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int pop_mode    = 0;
    int mode_left   = 0;

    brightness_gated_image_average uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in_item   (i_in_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] mean8(input logic [11:0] total, input logic [4:0] n);
        logic [11:0] q;
        if (n == 0)
            return '0;
        q = total / n;
        return q[7:0];
    endfunction

    task automatic fold_beat(input t_in_item b);
        logic [12:0] lhs;
        logic [11:0] rhs;
        t_out_item   px;
        lhs = 13'(b.pattern_level) * 13'(shadow_count);
        rhs = 12'(shadow_span) * 12'(b.image_index);
        if (lhs >= 13'(rhs) && acc_taken < MAX_IMAGES_DEF) begin
            acc_red   += 12'(b.pixel_red);
            acc_green += 12'(b.pixel_green);
            acc_blue  += 12'(b.pixel_blue);
            acc_taken += 5'd1;
        end
        if (b.last_image) begin
            px.avg_red        = mean8(acc_red, acc_taken);
            px.avg_green      = mean8(acc_green, acc_taken);
            px.avg_blue       = mean8(acc_blue, acc_taken);
            px.included_count = acc_taken;
            pending_pixels    = {pending_pixels, px};
            acc_red   = '0;
            acc_green = '0;
            acc_blue  = '0;
            acc_taken = '0;
        end
    endtask

    // Leaves push high; a gap lowers it once the burst runs out.
    task automatic push_beat(input t_in_item b, input bit typed = 1'b0,
                             input t_out_item want = '0);
        int gap;
        i_cfg_valid <= 1'b0;
        i_push      <= 1'b1;
        i_in_item   <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        fold_beat(b);
        if (typed) begin
            pending_pixels[pending_pixels.size() - 1] = want;
        end
        beats_in++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Beats without last_image may still be in flight, so settle after the drain.
    task automatic drain_and_settle();
        i_push      <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_IMAGE_COUNT)
            shadow_count = val[4:0];
        else if (idx == REG_CUTOFF_SPAN)
            shadow_span = val;
        cfg_writes++;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Result side: checks each beat taken and drives pop on its own pattern.
    always @(posedge i_clk) begin
        t_out_item px;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (!o_empty && i_pop) begin
                if (pending_pixels.size() == 0) begin
                    $error("result beat with no pixel outstanding");
                    err_cnt++;
                end else begin
                    px = pending_pixels.pop_front();
                    check_field("avg_red", px.avg_red, o_out_item.avg_red);
                    check_field("avg_green", px.avg_green, o_out_item.avg_green);
                    check_field("avg_blue", px.avg_blue, o_out_item.avg_blue);
                    check_field("included_count", 8'(px.included_count),
                                8'(o_out_item.included_count));
                end
                pixels_out++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (!hold_done && pixels_out == HOLD_AT) begin
                // long stall so the totals queue fills and full backs up
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                i_pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    pop_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (pop_mode)
                    0:       i_pop <= 1'b1;
                    1:       i_pop <= 1'($urandom_range(0, 1));
                    2:       i_pop <= ($urandom_range(0, 3) == 0);
                    default: i_pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        t_in_item    b;
        t_pixel_kind kind;
        logic [4:0]  cnt;
        logic [7:0]  spn;
        int          len;
        int          roll;
        int          phase_start;
        bit          paused;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                drain_and_settle();
                write_reg(SCRIPT[r].reg_idx, SCRIPT[r].reg_val);
            end else begin
                for (int k = 0; k < SCRIPT[r].reps; k++) begin
                    b = SCRIPT[r].beat;
                    b.last_image = SCRIPT[r].beat.last_image && (k == SCRIPT[r].reps - 1);
                    push_beat(b, SCRIPT[r].typed && b.last_image, SCRIPT[r].want);
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin cnt = 5'd16; spn = 8'd200; end
                1: begin cnt = 5'd1;  spn = 8'd255; end
                2: begin cnt = 5'd0;  spn = 8'd90;  end
                3: begin cnt = 5'd31; spn = 8'd0;   end
                default: begin
                    cnt = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(1, 16));
                    spn = 8'($urandom_range(0, 255));
                end
            endcase
            drain_and_settle();
            write_reg(REG_IMAGE_COUNT, CFG_DATA_W'(cnt));
            write_reg(REG_CUTOFF_SPAN, spn);
            phase_start = beats_in;
            paused      = 1'b0;
            while (beats_in - phase_start < RANDOM_BEATS / PHASES) begin
                roll = $urandom_range(0, 19);
                kind = (roll < 15) ? PIX_CLEAN : (roll < 19) ? PIX_NOISE : PIX_OVERLONG;
                case (kind)
                    PIX_CLEAN:
                        len = (cnt >= 1 && cnt <= 16 && $urandom_range(0, 2) != 0)
                              ? int'(cnt) : $urandom_range(1, 16);
                    PIX_NOISE: len = $urandom_range(1, 6);
                    default:   len = $urandom_range(17, 24);
                endcase
                for (int k = 0; k < len; k++) begin
                    b.pattern_level = ($urandom_range(0, 4) == 0)
                                      ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                      : 8'($urandom_range(0, 255));
                    b.pixel_red     = 8'($urandom_range(0, 255));
                    b.pixel_green   = 8'($urandom_range(0, 255));
                    b.pixel_blue    = 8'($urandom_range(0, 255));
                    b.last_image    = (k == len - 1);
                    case (kind)
                        PIX_CLEAN: b.image_index = 4'(k);
                        PIX_NOISE: begin
                            b.image_index = 4'($urandom_range(0, 15));
                            b.last_image  = b.last_image || ($urandom_range(0, 5) == 0);
                        end
                        default: begin
                            b.image_index   = 4'($urandom_range(0, 1));
                            b.pattern_level = 8'hFF;
                        end
                    endcase
                    // one pause mid-pixel until the output side has caught up
                    if (ph == 3 && !paused && beats_in - phase_start >= 30) begin
                        paused = 1'b1;
                        drain_and_settle();
                    end
                    push_beat(b);
                end
            end
        end

        drain_and_settle();
        $display("Covered %0d input beats, %0d pixel results, %0d register writes",
                 beats_in, pixels_out, cfg_writes);
        $display("incl. gate edges, empty and saturated pixels, and a long output stall.");
        if (err_cnt == 0 && pending_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
